// ===== rtl/efl_pkg.sv =====
package efl_pkg;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_LIMIT_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_LIMIT_RATIO     = 2'd1;
   localparam logic [1:0] CSR_ATTACK_COEF     = 2'd2;
   localparam logic [1:0] CSR_RELEASE_COEF    = 2'd3;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int LIMIT_BITS     = 15;
   localparam int COEF_BITS      = 16;
   localparam int ENV_BITS       = 32;

   // Reset values of the configuration registers
   localparam logic [LIMIT_BITS-1:0] THRESHOLD_RESET = 15'd19661;
   localparam logic [LIMIT_BITS-1:0] RATIO_RESET     = 15'd3277;
   localparam logic [COEF_BITS-1:0]  ATTACK_RESET    = 16'd64722;
   localparam logic [COEF_BITS-1:0]  RELEASE_RESET   = 16'd65508;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SATURATE,
      ST_MUL_RISE,
      ST_MUL_HOLD,
      ST_UPDATE,
      ST_ROOT_INIT,
      ST_ROOT,
      ST_DONE
   } efl_state_type;

   // Commands from the controller to the datapath, one step each
   typedef struct packed {
      logic load;
      logic square;
      logic saturate;
      logic mul_rise;
      logic mul_hold;
      logic update;
      logic root_init;
      logic root_step;
      logic out_load;
   } efl_cmd_type;

   typedef struct packed {
      logic out_free;
   } efl_status_type;

endpackage

// ===== rtl/efl_ctrl.sv =====
module efl_ctrl #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  efl_pkg::efl_status_type status,
   output efl_pkg::efl_cmd_type    cmd
);
   import efl_pkg::*;

   localparam int CNT_BITS = $clog2(SAMPLE_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(SAMPLE_BITS - 2);

   efl_state_type        state_ff, state_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_SQUARE;
         ST_SQUARE:    state_in = ST_SATURATE;
         ST_SATURATE:  state_in = ST_MUL_RISE;
         ST_MUL_RISE:  state_in = ST_MUL_HOLD;
         ST_MUL_HOLD:  state_in = ST_UPDATE;
         ST_UPDATE:    state_in = ST_ROOT_INIT;
         ST_ROOT_INIT: state_in = ST_ROOT;
         ST_ROOT:      if (cnt_ff == CNT_LAST) state_in = ST_DONE;
         ST_DONE:      if (status.out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Root step counter
   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == ST_ROOT_INIT) begin
         cnt_in = '0;
      end else if (state_ff == ST_ROOT) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_SQUARE:    cmd.square    = 1'b1;
         ST_SATURATE:  cmd.saturate  = 1'b1;
         ST_MUL_RISE:  cmd.mul_rise  = 1'b1;
         ST_MUL_HOLD:  cmd.mul_hold  = 1'b1;
         ST_UPDATE:    cmd.update    = 1'b1;
         ST_ROOT_INIT: cmd.root_init = 1'b1;
         ST_ROOT:      cmd.root_step = 1'b1;
         ST_DONE:      cmd.out_load  = status.out_free;
         default:      cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // One step per cycle at most
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("more than one datapath command");

   // A result is only written when the output register can take it
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded over a pending one");

   // The root runs exactly SAMPLE_BITS-1 steps
   a_root_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT && cnt_ff == CNT_LAST) |=> state_ff == ST_DONE)
      else $error("square root did not finish on time");

   // An accepted item starts the sequence
   a_start: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_SQUARE)
      else $error("accepted item did not start");

endmodule

// ===== rtl/efl_dpath.sv =====
module efl_dpath #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  efl_pkg::efl_cmd_type                   cmd,
   output efl_pkg::efl_status_type                status,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample_in,
   input  logic                                   req_block_end_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]          rsp_sample_out,
   output logic        [SAMPLE_BITS-1:0]          rsp_level_out,
   output logic                                   rsp_block_end_out,
   input  logic                                   csr_we,
   input  logic [efl_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [efl_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import efl_pkg::*;

   localparam int SB   = SAMPLE_BITS;
   localparam int FB   = SAMPLE_BITS - 1;
   localparam int RW   = 2 * FB;
   localparam int SQ_L = (RW <= ENV_BITS) ? ENV_BITS - RW : 0;
   localparam int SQ_R = (RW > ENV_BITS)  ? RW - ENV_BITS : 0;
   localparam int TH_L = (FB >= LIMIT_BITS) ? FB - LIMIT_BITS : 0;
   localparam int TH_R = (FB < LIMIT_BITS)  ? LIMIT_BITS - FB : 0;
   localparam int ACC_BITS = ENV_BITS + COEF_BITS + 1;

   // Configuration registers
   logic [LIMIT_BITS-1:0] thr_cfg_ff, thr_cfg_in;
   logic [LIMIT_BITS-1:0] ratio_ff, ratio_in;
   logic [COEF_BITS-1:0]  attack_ff, attack_in;
   logic [COEF_BITS-1:0]  release_ff, release_in;

   // Item and working registers
   logic [SB-1:0]         mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic                  blk_ff, blk_in;
   logic [63:0]           prod_ff, prod_in;
   logic [ENV_BITS-1:0]   sq32_ff, sq32_in;
   logic [COEF_BITS-1:0]  g_ff, g_in;
   logic                  over_ff, over_in;
   logic [SB-1:0]         thr_ff, thr_in;
   logic [SB-1:0]         excess_ff, excess_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [ENV_BITS-1:0]   env_ff, env_in;
   logic [SB-1:0]         om_ff, om_in;
   logic [RW-1:0]         rad_ff, rad_in;
   logic [FB+1:0]         rem_ff, rem_in;
   logic [FB-1:0]         root_ff, root_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]         rsp_sample_ff, rsp_sample_in;
   logic [SB-1:0]         rsp_level_ff, rsp_level_in;
   logic                  rsp_blk_ff, rsp_blk_in;

   logic [31:0]           mul_a, mul_b;
   logic [63:0]           sq_wide, thr_wide, rad_wide;
   logic [ACC_BITS:0]     acc_sum;
   logic [FB+1:0]         rem_sh, trial;
   logic                  ge;

   // Configuration writes
   always_comb begin
      thr_cfg_in = thr_cfg_ff;
      ratio_in   = ratio_ff;
      attack_in  = attack_ff;
      release_in = release_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LIMIT_THRESHOLD: thr_cfg_in = csr_wdata[LIMIT_BITS-1:0];
            CSR_LIMIT_RATIO:     ratio_in   = csr_wdata[LIMIT_BITS-1:0];
            CSR_ATTACK_COEF:     attack_in  = csr_wdata[COEF_BITS-1:0];
            CSR_RELEASE_COEF:    release_in = csr_wdata[COEF_BITS-1:0];
            default:             thr_cfg_in = thr_cfg_ff;
         endcase
      end
   end

   // Input capture: magnitude and sign
   always_comb begin
      mag_in = mag_ff;
      neg_in = neg_ff;
      blk_in = blk_ff;
      if (cmd.load) begin
         neg_in = req_sample_in[SB-1];
         mag_in = req_sample_in[SB-1] ? (~req_sample_in + 1'b1) : req_sample_in;
         blk_in = req_block_end_in;
      end
   end

   // Shared multiplier, operands picked by step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.square) begin
         mul_a = 32'(mag_ff);
         mul_b = 32'(mag_ff);
      end else if (cmd.mul_rise) begin
         mul_a = 32'(17'h10000 - {1'b0, g_ff});
         mul_b = sq32_ff;
      end else if (cmd.mul_hold) begin
         mul_a = 32'(g_ff);
         mul_b = env_ff;
      end else if (cmd.update) begin
         mul_a = 32'(ratio_ff);
         mul_b = 32'(excess_ff);
      end
      prod_in = mul_a * mul_b;
   end

   // Square to a 32-bit fraction, coefficient select, knee compare
   always_comb begin
      sq_wide   = (prod_ff << SQ_L) >> SQ_R;
      thr_wide  = (64'(thr_cfg_ff) << TH_L) >> TH_R;
      sq32_in   = sq32_ff;
      g_in      = g_ff;
      thr_in    = thr_ff;
      over_in   = over_ff;
      excess_in = excess_ff;
      if (cmd.saturate) begin
         sq32_in   = (|sq_wide[63:32]) ? '1 : sq_wide[31:0];
         g_in      = (sq32_in > env_ff) ? attack_ff : release_ff;
         thr_in    = thr_wide[SB-1:0];
         over_in   = mag_ff > thr_wide[SB-1:0];
         excess_in = mag_ff - thr_wide[SB-1:0];
      end
   end

   // One-pole filter accumulate and envelope update
   always_comb begin
      acc_in  = acc_ff;
      env_in  = env_ff;
      acc_sum = {1'b0, acc_ff} + (ACC_BITS + 1)'(prod_ff[ACC_BITS-1:0]);
      if (cmd.mul_hold) begin
         acc_in = prod_ff[ACC_BITS-1:0];
      end
      if (cmd.update) begin
         env_in = acc_sum[COEF_BITS +: ENV_BITS];
      end
   end

   // Limited magnitude and square root
   always_comb begin
      rad_wide = (64'(env_ff) << SQ_R) >> SQ_L;
      om_in    = om_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      rem_sh   = {rem_ff[FB-1:0], rad_ff[RW-1 -: 2]};
      trial    = {root_ff, 2'b01};
      ge       = rem_sh >= trial;
      if (cmd.root_init) begin
         om_in   = over_ff ? (thr_ff + prod_ff[LIMIT_BITS +: SB]) : mag_ff;
         rad_in  = rad_wide[RW-1:0];
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.root_step) begin
         rad_in  = rad_ff << 2;
         rem_in  = ge ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[FB-2:0], ge};
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_blk_in    = rsp_blk_ff;
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = neg_ff ? (~om_ff + 1'b1) : om_ff;
         rsp_level_in  = {1'b0, root_ff};
         rsp_blk_in    = blk_ff;
      end
   end

   assign status.out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_out    = rsp_sample_ff;
   assign rsp_level_out     = rsp_level_ff;
   assign rsp_block_end_out = rsp_blk_ff;

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_cfg_ff   <= THRESHOLD_RESET;
         ratio_ff     <= RATIO_RESET;
         attack_ff    <= ATTACK_RESET;
         release_ff   <= RELEASE_RESET;
         env_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_cfg_ff   <= thr_cfg_in;
         ratio_ff     <= ratio_in;
         attack_ff    <= attack_in;
         release_ff   <= release_in;
         env_ff       <= env_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      blk_ff        <= blk_in;
      prod_ff       <= prod_in;
      sq32_ff       <= sq32_in;
      g_ff          <= g_in;
      thr_ff        <= thr_in;
      over_ff       <= over_in;
      excess_ff     <= excess_in;
      acc_ff        <= acc_in;
      om_ff         <= om_in;
      rad_ff        <= rad_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_blk_ff    <= rsp_blk_in;
   end

   // The envelope only moves on the update step
   a_env_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.update |=> $stable(env_ff))
      else $error("envelope changed outside update");

   // The limiter never raises the magnitude
   a_om_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.root_step |-> om_ff <= mag_ff)
      else $error("limited magnitude above input");

   // The partial remainder stays below twice the root plus one
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.root_step |=> rem_ff <= {root_ff, 1'b0})
      else $error("square root remainder out of range");

endmodule

// ===== rtl/envelope_follower_limiter_core.sv =====
// Envelope follower with hard-knee limiter.
// Input channel req_*: one signed audio sample per item plus a buffer-end mark.
// Result channel rsp_*: one item per input: the limited sample, the level
// (square root of the smoothed square) and the buffer-end mark.
// Handshake: an item moves on a clock edge with valid high and stall low.
// Configuration: csr_we writes csr_wdata into register csr_index
// (0 threshold, 1 ratio, 2 attack coefficient, 3 release coefficient);
// write only while no item is in flight.
// The block takes no new item until the last one has reached the output
// register; the bit-serial square root, one result bit per cycle, takes most
// of the time, and one shared multiplier does the square, both filter taps and
// the ratio product. A finished result sits in the output register; the next
// item is taken and worked on while it waits, and only the final write-back
// waits for a stalled receiver.
// Reset: registers go to their defaults, the envelope to zero, no result valid.
module envelope_follower_limiter_core #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample_in,
   input  logic                                   req_block_end_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]          rsp_sample_out,
   output logic        [SAMPLE_BITS-1:0]          rsp_level_out,
   output logic                                   rsp_block_end_out,
   input  logic                                   csr_we,
   input  logic [efl_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [efl_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import efl_pkg::*;

   efl_cmd_type    cmd;
   efl_status_type status;

   efl_ctrl #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   efl_dpath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_sample_in     (req_sample_in),
      .req_block_end_in  (req_block_end_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_level_out     (rsp_level_out),
      .rsp_block_end_out (rsp_block_end_out),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

endmodule

// ===== tb/sv/tb_envelope_follower_limiter_core.sv =====
`timescale 1ns / 100ps

module tb_envelope_follower_limiter_core;
   import efl_pkg::*;

   localparam int SAMPLE_BITS    = 16;
   localparam int LATENCY        = SAMPLE_BITS + 6;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int RANDOM_PHASES  = 9;
   localparam int PHASE_ITEMS    = 200;
   localparam int LONG_HOLD      = 400;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          block_end;
   } sample_item_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic        [SAMPLE_BITS-1:0] level_out;
      logic                          block_end_out;
   } limited_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample_in = '0;
   logic                          req_block_end_in = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic        [SAMPLE_BITS-1:0] rsp_level_out;
   logic                          rsp_block_end_out;
   logic                          csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [CSR_DATA_BITS-1:0]      csr_wdata = '0;

   // Shadow copy of the block's registers and envelope
   logic [LIMIT_BITS-1:0] knee_level   = THRESHOLD_RESET;
   logic [LIMIT_BITS-1:0] knee_slope   = RATIO_RESET;
   logic [COEF_BITS-1:0]  rise_coef    = ATTACK_RESET;
   logic [COEF_BITS-1:0]  fall_coef    = RELEASE_RESET;
   logic [ENV_BITS-1:0]   envelope_est = '0;

   sample_item_type    pending_samples[$];
   limited_result_type predicted_results[$];

   int error_count = 0;
   int cycle_count = 0;
   bit long_hold_req = 1'b0;

   envelope_follower_limiter_core #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .req_block_end_in (req_block_end_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_level_out    (rsp_level_out),
      .rsp_block_end_out(rsp_block_end_out),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Floor of the square root, one result bit at a time from the top
   function automatic logic [SAMPLE_BITS-1:0] floor_root(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = SAMPLE_BITS - 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root[SAMPLE_BITS-1:0];
   endfunction

   // Square, smooth into the envelope, take the level, and limit the sample
   function automatic limited_result_type follow_and_limit(input sample_item_type item);
      limited_result_type res;
      logic        neg;
      logic [63:0] mag, square, gain, acc, knee, out_mag;
      neg = item.sample[SAMPLE_BITS-1];
      mag = neg ? (64'd1 << SAMPLE_BITS) - {48'd0, item.sample} : {48'd0, item.sample};
      square = (mag * mag) << 2;
      if (square > 64'hFFFF_FFFF) square = 64'hFFFF_FFFF;
      gain = (square > {32'd0, envelope_est}) ? {48'd0, rise_coef} : {48'd0, fall_coef};
      acc = (64'd65536 - gain) * square + gain * {32'd0, envelope_est};
      envelope_est = acc[47:16];
      res.level_out = floor_root({32'd0, envelope_est} >> 2);
      knee = {49'd0, knee_level};
      out_mag = mag;
      if (mag > knee) out_mag = knee + (({49'd0, knee_slope} * (mag - knee)) >> 15);
      res.sample_out = neg ? SAMPLE_BITS'((64'd1 << SAMPLE_BITS) - out_mag)
                           : SAMPLE_BITS'(out_mag);
      res.block_end_out = item.block_end;
      return res;
   endfunction

   // Driver: bursts of items with random gaps; prediction at acceptance
   int              burst_left = 0;
   int              gap_left = 0;
   sample_item_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            next_item.sample = req_sample_in;
            next_item.block_end = req_block_end_in;
            predicted_results.push_back(follow_and_limit(next_item));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               next_item = pending_samples.pop_front();
               req_sample_in <= next_item.sample;
               req_block_end_in <= next_item.block_end;
               req_valid <= 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: modes of varying density, plus an occasional long hold-off
   int hold_left = 0;
   int mode_left = 0;
   int stall_mode = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(10, 200);
            end
            mode_left--;
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   // Monitor: compare each result with the oldest prediction
   limited_result_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_results.size() == 0) begin
            $error("unexpected result: sample_out %0d level_out %0d",
                   rsp_sample_out, rsp_level_out);
            error_count++;
         end else begin
            want = predicted_results.pop_front();
            if (rsp_sample_out !== want.sample_out) begin
               $error("sample_out mismatch: expected %0d, actual %0d",
                      want.sample_out, rsp_sample_out);
               error_count++;
            end
            if (rsp_level_out !== want.level_out) begin
               $error("level_out mismatch: expected %0d, actual %0d",
                      want.level_out, rsp_level_out);
               error_count++;
            end
            if (rsp_block_end_out !== want.block_end_out) begin
               $error("block_end_out mismatch: expected %0d, actual %0d",
                      want.block_end_out, rsp_block_end_out);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Register write; the shadow copy keeps only the register's width
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_LIMIT_THRESHOLD: knee_level = data[LIMIT_BITS-1:0];
         CSR_LIMIT_RATIO:     knee_slope = data[LIMIT_BITS-1:0];
         CSR_ATTACK_COEF:     rise_coef = data;
         CSR_RELEASE_COEF:    fall_coef = data;
         default: ;
      endcase
   endtask

   task automatic write_all(input int thr, input int ratio, input int att, input int rel);
      // junk in the unused top bit of the 15-bit registers must be dropped
      write_reg(CSR_LIMIT_THRESHOLD, {1'($urandom_range(0, 1)), 15'(thr)});
      write_reg(CSR_LIMIT_RATIO, {1'($urandom_range(0, 1)), 15'(ratio)});
      write_reg(CSR_ATTACK_COEF, 16'(att));
      write_reg(CSR_RELEASE_COEF, 16'(rel));
   endtask

   task automatic queue_sample(input int value, input bit mark);
      sample_item_type item;
      item.sample = SAMPLE_BITS'(value);
      item.block_end = mark;
      pending_samples.push_back(item);
   endtask

   // Wait until everything sent has come back and the block has settled
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || predicted_results.size() != 0);
      repeat (LATENCY + 8) @(negedge clock);
   endtask

   // Random samples in segments: loud, quiet, around the knee, extremes, anything
   task automatic queue_random(input int count);
      int seg_left;
      int kind;
      int mag;
      int value;
      seg_left = 0;
      kind = 0;
      for (int n = 0; n < count; n++) begin
         if (seg_left == 0) begin
            kind = $urandom_range(0, 4);
            seg_left = $urandom_range(5, 60);
         end
         seg_left--;
         case (kind)
            0: value = $urandom_range(0, 65535) - 32768;
            1: value = $urandom_range(0, 511) - 256;
            2: begin
               mag = int'(knee_level) + $urandom_range(0, 64) - 32;
               if (mag < 0) mag = 0;
               value = $urandom_range(0, 1) ? -mag : mag;
            end
            3: begin
               case ($urandom_range(0, 5))
                  0: value = -32768;
                  1: value = 32767;
                  2: value = -32767;
                  3: value = 0;
                  4: value = 1;
                  default: value = -1;
               endcase
            end
            default: begin
               mag = $urandom_range(24000, 32768);
               value = $urandom_range(0, 1) ? -mag : mag;
            end
         endcase
         queue_sample(value, $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: defaults, zero, unit steps, full scale, both sides of the knee
      queue_sample(0, 1'b0);
      queue_sample(1, 1'b1);
      queue_sample(-1, 1'b0);
      queue_sample(32767, 1'b1);
      queue_sample(-32768, 1'b0);
      queue_sample(-32767, 1'b1);
      queue_sample(19661, 1'b0);
      queue_sample(19662, 1'b1);
      queue_sample(-19661, 1'b0);
      queue_sample(-19662, 1'b1);
      queue_sample(16384, 1'b0);
      queue_sample(-16384, 1'b0);
      queue_sample(100, 1'b1);
      queue_sample(-100, 1'b0);
      queue_sample(32767, 1'b0);
      queue_sample(0, 1'b1);
      queue_sample(0, 1'b0);
      wait_drained();

      // Knee at zero: every nonzero sample goes through the slope
      write_all(0, 32767, 65535, 0);
      queue_sample(1, 1'b1);
      queue_sample(-1, 1'b0);
      queue_sample(0, 1'b1);
      queue_sample(32767, 1'b0);
      queue_sample(-32768, 1'b1);
      queue_sample(2, 1'b0);
      wait_drained();

      // Random phases, each with its own register setting
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: write_all(0, 32767, 0, 65535);
            1: write_all(32767, 0, 65535, 0);
            2: write_all(THRESHOLD_RESET, RATIO_RESET, ATTACK_RESET, RELEASE_RESET);
            default: write_all($urandom_range(0, 32767), $urandom_range(0, 32767),
                               $urandom_range(0, 65535), $urandom_range(0, 65535));
         endcase
         if (p == 0 || p == 5) long_hold_req = 1'b1;
         queue_random(PHASE_ITEMS);
         wait_drained();
      end

      if (error_count == 0 && predicted_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== envelope_follower_limiter_core.f =====
rtl/efl_pkg.sv
rtl/efl_ctrl.sv
rtl/efl_dpath.sv
rtl/envelope_follower_limiter_core.sv
tb/sv/tb_envelope_follower_limiter_core.sv
